### sv/qslerp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and tables for the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int ISQRT_STEPS  = 29;
    localparam int DIV_STEPS    = 18;

    localparam int CW     = 32;   // CORDIC word
    localparam int SQ_W   = 58;   // isqrt working width
    localparam int SN_W   = 29;   // sin(omega), Q28, up to 2^28
    localparam int NUM_W  = 47;   // divider numerator
    localparam int Q_W    = 18;   // raw quotient
    localparam int K_W    = 17;   // weight, Q15, up to 65536
    localparam int THR_W  = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd16383;
    localparam logic [0:0] REG_LINEAR_THRESHOLD = 1'b0;

    localparam logic [K_W-1:0] ONE_Q15 = 17'd32768;
    localparam logic [K_W-1:0] K_MAX   = 17'd65536;

    // pipeline stage map
    localparam int ST_IN   = 0;
    localparam int ST_DOT  = ST_IN + 1;
    localparam int ST_ABS  = ST_DOT + 1;
    localparam int ST_RAD  = ST_ABS + 1;
    localparam int ST_SQ0  = ST_RAD + 1;
    localparam int ST_VEC0 = ST_SQ0 + ISQRT_STEPS;
    localparam int ST_ANG  = ST_VEC0 + CORDIC_STEPS;
    localparam int ST_ROT0 = ST_ANG + 1;
    localparam int ST_DIV0 = ST_ROT0 + CORDIC_STEPS;
    localparam int ST_MUL  = ST_DIV0 + DIV_STEPS;

    typedef logic signed [CW-1:0] cword_t;

    // item context carried alongside the datapath
    typedef struct packed {
        logic [3:0][15:0]  s;
        logic [3:0][15:0]  e;
        logic [14:0]       t;
        logic              byp_s;
        logic              byp_e;
        logic              neg;
        logic              trig;
        logic [27:0]       ad;
        logic [SN_W-1:0]   sn;
    } side_t;

    typedef struct packed {
        logic [3:0][15:0] q;
    } res_t;

    // atan(2^-i) in Q29 radians
    function automatic cword_t atan_q29(input logic [4:0] idx);
        cword_t a;
        case (idx)
            5'd0:  a = 32'sd421657428;
            5'd1:  a = 32'sd248918915;
            5'd2:  a = 32'sd131521918;
            5'd3:  a = 32'sd66762579;
            5'd4:  a = 32'sd33510843;
            5'd5:  a = 32'sd16771758;
            5'd6:  a = 32'sd8387925;
            5'd7:  a = 32'sd4194219;
            5'd8:  a = 32'sd2097141;
            5'd9:  a = 32'sd1048575;
            5'd10: a = 32'sd524288;
            5'd11: a = 32'sd262144;
            5'd12: a = 32'sd131072;
            5'd13: a = 32'sd65536;
            5'd14: a = 32'sd32768;
            5'd15: a = 32'sd16384;
            5'd16: a = 32'sd8192;
            5'd17: a = 32'sd4096;
            5'd18: a = 32'sd2048;
            5'd19: a = 32'sd1024;
            5'd20: a = 32'sd512;
            5'd21: a = 32'sd256;
            5'd22: a = 32'sd128;
            5'd23: a = 32'sd64;
            5'd24: a = 32'sd32;
            5'd25: a = 32'sd16;
            5'd26: a = 32'sd8;
            5'd27: a = 32'sd4;
            default: a = '0;
        endcase
        return a;
    endfunction

    localparam cword_t INV_GAIN = 32'sd163008219;

endpackage
`default_nettype wire

### sv/qslerp_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_cordic
// Fully pipelined CORDIC, one micro-rotation per stage, vectoring or rotation.
// ----------------------------------------------------------------------------
module qslerp_cordic #(
    parameter bit VECTORING = 1'b0
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire qslerp_pkg::cword_t x_in,
    input  wire qslerp_pkg::cword_t y_in,
    input  wire qslerp_pkg::cword_t z_in,
    output qslerp_pkg::cword_t      x_out,
    output qslerp_pkg::cword_t      y_out,
    output qslerp_pkg::cword_t      z_out
);

    localparam int N = qslerp_pkg::CORDIC_STEPS;

    qslerp_pkg::cword_t x_reg [N];
    qslerp_pkg::cword_t y_reg [N];
    qslerp_pkg::cword_t z_reg [N];
    qslerp_pkg::cword_t x_next [N];
    qslerp_pkg::cword_t y_next [N];
    qslerp_pkg::cword_t z_next [N];

    always_comb begin
        qslerp_pkg::cword_t xp, yp, zp, dx, dy, at;
        logic dir;
        for (int k = 0; k < N; k++) begin
            xp = (k == 0) ? x_in : x_reg[(k == 0) ? 0 : k - 1];
            yp = (k == 0) ? y_in : y_reg[(k == 0) ? 0 : k - 1];
            zp = (k == 0) ? z_in : z_reg[(k == 0) ? 0 : k - 1];
            dx = yp >>> k;
            dy = xp >>> k;
            at = qslerp_pkg::atan_q29(5'(k));
            // vectoring drives y to zero, rotation drives z to zero
            dir = VECTORING ? (yp > 0) : (zp < 0);
            if (dir) begin
                x_next[k] = xp + dx;
                y_next[k] = yp - dy;
                z_next[k] = zp + at;
            end else begin
                x_next[k] = xp - dx;
                y_next[k] = yp + dy;
                z_next[k] = zp - at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign x_out = x_reg[N-1];
    assign y_out = y_reg[N-1];
    assign z_out = z_reg[N-1];

endmodule
`default_nettype wire

### sv/qslerp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module qslerp_div (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [qslerp_pkg::NUM_W-1:0] num_in,
    input  wire logic [qslerp_pkg::SN_W-1:0]  den_in,
    output logic      [qslerp_pkg::Q_W-1:0]   q_out
);

    localparam int N     = qslerp_pkg::DIV_STEPS;
    localparam int NW    = qslerp_pkg::NUM_W;
    localparam int DW    = qslerp_pkg::SN_W;
    localparam int QW    = qslerp_pkg::Q_W;

    logic [NW-1:0] rem_reg [N];
    logic [DW-1:0] den_reg [N];
    logic [QW-1:0] q_reg   [N];
    logic [NW-1:0] rem_next [N];
    logic [DW-1:0] den_next [N];
    logic [QW-1:0] q_next   [N];

    always_comb begin
        logic [NW-1:0] rp, sh;
        logic [DW-1:0] dp;
        logic [QW-1:0] qp;
        for (int j = 0; j < N; j++) begin
            rp = (j == 0) ? num_in : rem_reg[(j == 0) ? 0 : j - 1];
            dp = (j == 0) ? den_in : den_reg[(j == 0) ? 0 : j - 1];
            qp = (j == 0) ? '0     : q_reg[(j == 0) ? 0 : j - 1];
            sh = {{(NW-DW){1'b0}}, dp} << (N - 1 - j);
            den_next[j] = dp;
            // a set top bit already means "saturate", so overshoot is harmless
            if (rp >= sh) begin
                rem_next[j] = rp - sh;
                q_next[j]   = qp | (QW'(1) << (N - 1 - j));
            end else begin
                rem_next[j] = rp;
                q_next[j]   = qp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < N; j++) begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_next[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign q_out = q_reg[N-1];

endmodule
`default_nettype wire

### sv/quaternion_slerp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp_core
// Spherical linear interpolation of two Q2.14 quaternions by a Q15 blend.
// ----------------------------------------------------------------------------
// Pipeline: the input transfer loads stage 0, then 108 more pipeline stages
//   follow, then the output register.
// Throughput: one transfer per cycle while s_ready is high; the pipeline
//   length is set by the 29-step isqrt, two 28-step CORDIC passes and the
//   18-step divider.
// Reset (aresetn low, synchronous): all valid flags clear, linear_threshold
//   returns to 16383. Datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_slerp_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_start_w,
    input  wire logic signed [15:0]   s_start_x,
    input  wire logic signed [15:0]   s_start_y,
    input  wire logic signed [15:0]   s_start_z,
    input  wire logic signed [15:0]   s_end_w,
    input  wire logic signed [15:0]   s_end_x,
    input  wire logic signed [15:0]   s_end_y,
    input  wire logic signed [15:0]   s_end_z,
    input  wire logic signed [16:0]   s_blend,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_out_w,
    output logic signed [15:0]        m_out_x,
    output logic signed [15:0]        m_out_y,
    output logic signed [15:0]        m_out_z,
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int ST_ABS  = qslerp_pkg::ST_ABS;
    localparam int ST_VEC0 = qslerp_pkg::ST_VEC0;
    localparam int ST_DIV0 = qslerp_pkg::ST_DIV0;
    localparam int ST_MUL  = qslerp_pkg::ST_MUL;
    localparam int NSQ     = qslerp_pkg::ISQRT_STEPS;
    localparam int SQ_W    = qslerp_pkg::SQ_W;
    localparam int SN_W    = qslerp_pkg::SN_W;
    localparam int K_W     = qslerp_pkg::K_W;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [qslerp_pkg::THR_W-1:0] thr_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= qslerp_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == qslerp_pkg::REG_LINEAR_THRESHOLD) begin
            thr_reg <= pwdata[qslerp_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            qslerp_pkg::REG_LINEAR_THRESHOLD: prdata = {17'd0, thr_reg};
            default:                          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stall control: one global enable. The pipeline keeps moving while
    // the output register holds a result, a skid entry catches one more.
    // ------------------------------------------------------------------
    logic              en;
    logic [ST_MUL:0]   vld_reg;
    logic              out_vld_reg, skid_vld_reg;
    qslerp_pkg::res_t  out_reg, skid_reg, res_next;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ST_MUL-1:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // Item context shift line
    // ------------------------------------------------------------------
    qslerp_pkg::side_t side_reg [ST_MUL+1];
    qslerp_pkg::side_t side_in, side_abs_next, side_vec_next;

    always_comb begin
        side_in       = '0;
        side_in.s     = {s_start_z, s_start_y, s_start_x, s_start_w};
        side_in.e     = {s_end_z, s_end_y, s_end_x, s_end_w};
        side_in.t     = s_blend[14:0];
        side_in.byp_s = (s_blend <= 17'sd0);
        side_in.byp_e = (s_blend >= 17'sd32768);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= ST_MUL; i++) begin
                if (i == ST_ABS)
                    side_reg[i] <= side_abs_next;
                else if (i == ST_VEC0)
                    side_reg[i] <= side_vec_next;
                else
                    side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Dot product: four products, then the sum
    // ------------------------------------------------------------------
    logic signed [31:0] prod_reg [4];
    logic signed [33:0] dot_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= s_start_w * s_end_w;
            prod_reg[1] <= s_start_x * s_end_x;
            prod_reg[2] <= s_start_y * s_end_y;
            prod_reg[3] <= s_start_z * s_end_z;
            dot_reg <= $signed({{2{prod_reg[0][31]}}, prod_reg[0]})
                     + $signed({{2{prod_reg[1][31]}}, prod_reg[1]})
                     + $signed({{2{prod_reg[2][31]}}, prod_reg[2]})
                     + $signed({{2{prod_reg[3][31]}}, prod_reg[3]});
        end
    end

    // ------------------------------------------------------------------
    // Shorter arc, path select, 1 - c^2
    // ------------------------------------------------------------------
    logic [33:0] ad_full;
    logic [55:0] dsq_reg;
    logic [SQ_W-1:0] rad_reg;

    assign ad_full = dot_reg[33] ? 34'(-dot_reg) : dot_reg;

    always_comb begin
        side_abs_next      = side_reg[ST_ABS-1];
        side_abs_next.neg  = dot_reg[33];
        side_abs_next.ad   = ad_full[27:0];
        // trig path only for cosine at or below the threshold and below one
        side_abs_next.trig = (ad_full[33:14] <= {5'd0, thr_reg})
                             && (ad_full[33:28] == 6'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsq_reg <= ad_full[27:0] * ad_full[27:0];
            rad_reg <= (SQ_W'(1) << 56) - {2'd0, dsq_reg};
        end
    end

    // ------------------------------------------------------------------
    // sin(omega) = isqrt(2^56 - d^2), one result bit per stage
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] sq_v_reg [NSQ];
    logic [SQ_W-1:0] sq_r_reg [NSQ];
    logic [SQ_W-1:0] sq_v_next [NSQ];
    logic [SQ_W-1:0] sq_r_next [NSQ];

    always_comb begin
        logic [SQ_W-1:0] vp, rp, bt, rb;
        for (int k = 0; k < NSQ; k++) begin
            vp = (k == 0) ? rad_reg : sq_v_reg[(k == 0) ? 0 : k - 1];
            rp = (k == 0) ? '0      : sq_r_reg[(k == 0) ? 0 : k - 1];
            bt = SQ_W'(1) << (2 * (NSQ - 1 - k));
            rb = rp + bt;
            if (vp >= rb) begin
                sq_v_next[k] = vp - rb;
                sq_r_next[k] = (rp >> 1) + bt;
            end else begin
                sq_v_next[k] = vp;
                sq_r_next[k] = rp >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NSQ; k++) begin
                sq_v_reg[k] <= sq_v_next[k];
                sq_r_reg[k] <= sq_r_next[k];
            end
        end
    end

    logic [SN_W-1:0] sn;
    assign sn = sq_r_reg[NSQ-1][SN_W-1:0];

    always_comb begin
        side_vec_next      = side_reg[ST_VEC0-1];
        side_vec_next.sn   = sn;
        side_vec_next.trig = side_reg[ST_VEC0-1].trig && (sn != '0);
    end

    // ------------------------------------------------------------------
    // omega = atan2(sin, cos) by vectoring
    // ------------------------------------------------------------------
    qslerp_pkg::cword_t vec_x, vec_y, omega;

    qslerp_cordic #(.VECTORING(1'b1)) u_vec (
        .aclk  (aclk),
        .en    (en),
        .x_in  ($signed({4'd0, side_reg[ST_VEC0-1].ad})),
        .y_in  ($signed({{(qslerp_pkg::CW-SN_W){1'b0}}, sn})),
        .z_in  ('0),
        .x_out (vec_x),
        .y_out (vec_y),
        .z_out (omega)
    );

    // ------------------------------------------------------------------
    // Angles (1-t)*omega and t*omega
    // ------------------------------------------------------------------
    logic [15:0]          tc;
    logic signed [48:0]   ang0_p, ang1_p;
    qslerp_pkg::cword_t   a0_reg, a1_reg;

    assign tc     = 16'd32768 - {1'b0, side_reg[qslerp_pkg::ST_ANG-1].t};
    assign ang0_p = $signed({1'b0, tc}) * omega;
    assign ang1_p = $signed({2'b0, side_reg[qslerp_pkg::ST_ANG-1].t}) * omega;

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= ang0_p[46:15];
            a1_reg <= ang1_p[46:15];
        end
    end

    // ------------------------------------------------------------------
    // sin of both angles
    // ------------------------------------------------------------------
    qslerp_pkg::cword_t rot0_x, rot0_y, rot0_z, rot1_x, rot1_y, rot1_z;

    qslerp_cordic #(.VECTORING(1'b0)) u_rot0 (
        .aclk  (aclk),
        .en    (en),
        .x_in  (qslerp_pkg::INV_GAIN),
        .y_in  ('0),
        .z_in  (a0_reg),
        .x_out (rot0_x),
        .y_out (rot0_y),
        .z_out (rot0_z)
    );

    qslerp_cordic #(.VECTORING(1'b0)) u_rot1 (
        .aclk  (aclk),
        .en    (en),
        .x_in  (qslerp_pkg::INV_GAIN),
        .y_in  ('0),
        .z_in  (a1_reg),
        .x_out (rot1_x),
        .y_out (rot1_y),
        .z_out (rot1_z)
    );

    // ------------------------------------------------------------------
    // Weights: max(sin a, 0) * 2^15 / sin(omega)
    // ------------------------------------------------------------------
    logic [qslerp_pkg::NUM_W-1:0] num0, num1;
    logic [qslerp_pkg::Q_W-1:0]   q0, q1;

    assign num0 = rot0_y[31] ? '0 : {rot0_y, 15'd0};
    assign num1 = rot1_y[31] ? '0 : {rot1_y, 15'd0};

    qslerp_div u_div0 (
        .aclk   (aclk),
        .en     (en),
        .num_in (num0),
        .den_in (side_reg[ST_DIV0-1].sn),
        .q_out  (q0)
    );

    qslerp_div u_div1 (
        .aclk   (aclk),
        .en     (en),
        .num_in (num1),
        .den_in (side_reg[ST_DIV0-1].sn),
        .q_out  (q1)
    );

    // ------------------------------------------------------------------
    // Weighted products
    // ------------------------------------------------------------------
    qslerp_pkg::side_t   sm;
    logic [K_W-1:0]      k0, k1;
    logic signed [16:0]  ep [4];
    logic signed [35:0]  p0_reg [4];
    logic signed [35:0]  p1_reg [4];

    assign sm = side_reg[ST_MUL-1];

    always_comb begin
        if (sm.trig) begin
            k0 = (q0 > {1'b0, qslerp_pkg::K_MAX}) ? qslerp_pkg::K_MAX : q0[K_W-1:0];
            k1 = (q1 > {1'b0, qslerp_pkg::K_MAX}) ? qslerp_pkg::K_MAX : q1[K_W-1:0];
        end else begin
            k0 = qslerp_pkg::ONE_Q15 - {2'd0, sm.t};
            k1 = {2'd0, sm.t};
        end
        for (int j = 0; j < 4; j++) begin
            ep[j] = sm.neg ? -$signed({sm.e[j][15], sm.e[j]})
                           :  $signed({sm.e[j][15], sm.e[j]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                p0_reg[j] <= 36'($signed({1'b0, k0}) * $signed(sm.s[j]));
                p1_reg[j] <= 36'($signed({1'b0, k1}) * ep[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Round, saturate, bypass select
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [35:0] acc, sh;
        res_next = '0;
        for (int j = 0; j < 4; j++) begin
            acc = p0_reg[j] + p1_reg[j] + 36'sd16384;
            sh  = acc >>> 15;
            if (side_reg[ST_MUL].byp_s)
                res_next.q[j] = side_reg[ST_MUL].s[j];
            else if (side_reg[ST_MUL].byp_e)
                res_next.q[j] = side_reg[ST_MUL].e[j];
            else if (sh > 36'sd32767)
                res_next.q[j] = 16'h7fff;
            else if (sh < -36'sd32768)
                res_next.q[j] = 16'h8000;
            else
                res_next.q[j] = sh[15:0];
        end
    end

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg <= vld_reg[ST_MUL];
        end else if (vld_reg[ST_MUL]) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready)
                out_reg <= skid_reg;
        end else if (!out_vld_reg || m_ready) begin
            out_reg <= res_next;
        end else begin
            skid_reg <= res_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_out_w = out_reg.q[0];
    assign m_out_x = out_reg.q[1];
    assign m_out_y = out_reg.q[2];
    assign m_out_z = out_reg.q[3];

endmodule
`default_nettype wire

### sv/qslerp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qslerp_checker
// Port-level checks on the slerp core, bound to the top level.
// ----------------------------------------------------------------------------
module qslerp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_out_w,
    input wire logic signed [15:0] m_out_x,
    input wire logic signed [15:0] m_out_y,
    input wire logic signed [15:0] m_out_z
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_w) && $stable(m_out_x)
                               && $stable(m_out_y) && $stable(m_out_z))
        else $error("result changed while stalled");

    // input side only backs off when a result is waiting
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no pending result");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind quaternion_slerp_core qslerp_checker u_qslerp_checker (.*);
`default_nettype wire

### verif/tb_quaternion_slerp_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_core
// Self-checking bench for the quaternion slerp core. A queue of pending items
// feeds a clocked driver, and a clocked monitor checks every result against a
// bit-exact integer slerp predictor. The threshold register is swept between
// phases. Random gaps on both sides, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_core;

    localparam int LAT_WAIT  = 130;   // pipeline drain margin
    localparam int WD_LIMIT  = 5000;  // cycles without any transfer while busy
    localparam int HOLD_LEN  = 400;   // receiver hold-off, longer than the pipe
    localparam int N_RANDOM  = 260;   // random items per phase

    typedef struct {
        logic signed [15:0] s[4];
        logic signed [15:0] e[4];
        logic signed [16:0] t;
    } slerp_item_t;

    typedef struct {
        logic signed [15:0] q[4];
    } quat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_start_w = '0, s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic signed [15:0] s_end_w = '0, s_end_x = '0, s_end_y = '0, s_end_z = '0;
    logic signed [16:0] s_blend = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_out_w, m_out_x, m_out_y, m_out_z;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    quaternion_slerp_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_w(s_start_w), .s_start_x(s_start_x),
        .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_end_w(s_end_w), .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z),
        .s_blend(s_blend),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_w(m_out_w), .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    slerp_item_t pending_items[$];
    quat_t       expected_quats[$];
    logic [14:0] thr_shadow = qslerp_pkg::THR_RESET;   // testbench copy of linear_threshold
    int          n_errors = 0;
    int          n_in = 0, n_out = 0, n_trig = 0, n_lin = 0, n_byp = 0;

    // ------------------------------------------------------------------------
    // Integer slerp predictor
    // ------------------------------------------------------------------------
    longint atan_tab[28] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
        4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4};

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // angle of (x, y) by vectoring, Q29
    function automatic longint vec_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint rot_sin(longint a);
        longint x, y, dx, dy;
        x = 163008219;
        y = 0;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x = x - dx; y = y + dy; a = a - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; a = a + atan_tab[i];
            end
        end
        return y;
    endfunction

    function automatic longint arc_weight(longint sn, longint sw);
        longint k;
        if (sn < 0) sn = 0;
        k = (sn * 32768) / sw;
        return (k > 65536) ? 64'sd65536 : k;
    endfunction

    function automatic quat_t slerp_predict(slerp_item_t it);
        quat_t  r;
        longint sv[4], ev[4], t, dot, k0, k1, sn, w, acc, v;
        t = it.t;
        for (int j = 0; j < 4; j++) begin
            sv[j] = it.s[j];
            ev[j] = it.e[j];
        end
        if (t <= 0) begin
            r.q = it.s;
            n_byp++;
            return r;
        end
        if (t >= 32768) begin
            r.q = it.e;
            n_byp++;
            return r;
        end
        dot = 0;
        for (int j = 0; j < 4; j++) dot += sv[j] * ev[j];
        if (dot < 0) begin
            dot = -dot;
            for (int j = 0; j < 4; j++) ev[j] = -ev[j];
        end
        k0 = 32768 - t;
        k1 = t;
        n_lin++;
        if ((dot >>> 14) <= longint'(thr_shadow) && dot < (64'sd1 <<< 28)) begin
            sn = int_sqrt((64'd1 << 56) - longint'(dot) * longint'(dot));
            if (sn > 0) begin
                w  = vec_angle(dot, sn);
                k0 = arc_weight(rot_sin(((32768 - t) * w) >>> 15), sn);
                k1 = arc_weight(rot_sin((t * w) >>> 15), sn);
                n_trig++;
                n_lin--;
            end
        end
        for (int j = 0; j < 4; j++) begin
            acc = k0 * sv[j] + k1 * ev[j];
            v = (acc + 16384) >>> 15;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.q[j] = v[15:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one item per transfer, random gap drawn per item
    // ------------------------------------------------------------------------
    int  drv_gap = 0;
    bit  drv_burst = 0;

    always @(posedge aclk) begin
        slerp_item_t cur, nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.s = '{s_start_w, s_start_x, s_start_y, s_start_z};
                cur.e = '{s_end_w, s_end_x, s_end_y, s_end_z};
                cur.t = s_blend;
                expected_quats.push_back(slerp_predict(cur));
                n_in++;
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    s_start_w <= nxt.s[0]; s_start_x <= nxt.s[1];
                    s_start_y <= nxt.s[2]; s_start_z <= nxt.s[3];
                    s_end_w <= nxt.e[0]; s_end_x <= nxt.e[1];
                    s_end_y <= nxt.e[2]; s_end_z <= nxt.e[3];
                    s_blend <= nxt.t;
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 99) == 0) drv_burst = !drv_burst;
                    drv_gap = drv_burst ? 0 : $urandom_range(0, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transfer, drives m_ready with random
    // stalls and one long hold-off so the pipe fills and s_ready drops
    // ------------------------------------------------------------------------
    int  mon_stall = 0;
    int  mon_hold = 0;
    bit  mon_held = 0;
    bit  mon_burst = 0;

    always @(posedge aclk) begin
        quat_t exp_q, got_q;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_q.q = '{m_out_w, m_out_x, m_out_y, m_out_z};
                n_out++;
                if (expected_quats.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_errors++;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (got_q.q[0] !== exp_q.q[0]) begin
                        $error("out_w exp %0d got %0d", exp_q.q[0], got_q.q[0]);
                        n_errors++;
                    end
                    if (got_q.q[1] !== exp_q.q[1]) begin
                        $error("out_x exp %0d got %0d", exp_q.q[1], got_q.q[1]);
                        n_errors++;
                    end
                    if (got_q.q[2] !== exp_q.q[2]) begin
                        $error("out_y exp %0d got %0d", exp_q.q[2], got_q.q[2]);
                        n_errors++;
                    end
                    if (got_q.q[3] !== exp_q.q[3]) begin
                        $error("out_z exp %0d got %0d", exp_q.q[3], got_q.q[3]);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 99) == 0) mon_burst = !mon_burst;
                mon_stall = mon_burst ? 0 : $urandom_range(0, 14);
            end
            if (!mon_held && n_out >= 200) begin
                mon_held = 1;
                mon_hold = HOLD_LEN;
            end
            if (mon_hold > 0) begin
                mon_hold--;
                m_ready <= 1'b0;
            end else if (mon_stall > 0) begin
                mon_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with outstanding work but no transfer on either side
    // ------------------------------------------------------------------------
    int wd_count = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            wd_count = 0;
        end else if (pending_items.size() > 0 || expected_quats.size() > 0 || s_valid) begin
            wd_count++;
            if (wd_count >= WD_LIMIT) begin
                $display("timeout: %0d items in, %0d results out", n_in, n_out);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // random quaternion scaled to unit norm (16384), or raw when not normalized
    function automatic void rand_quat(output logic signed [15:0] q[4], input bit unit);
        real c[4], n;
        n = 0.0;
        for (int j = 0; j < 4; j++) begin
            c[j] = real'(int'($urandom_range(0, 32768)) - 16384);
            n += c[j] * c[j];
        end
        if (n < 1.0) begin
            c[0] = 16384.0;
            n = 16384.0 * 16384.0;
        end
        for (int j = 0; j < 4; j++)
            q[j] = unit ? 16'(int'(c[j] * 16384.0 / $sqrt(n))) : 16'($urandom());
    endfunction

    // end quaternion near the start one, to reach small angles and linear path
    function automatic void near_quat(output logic signed [15:0] q[4],
                                      input logic signed [15:0] base[4], int spread);
        real c[4], n;
        n = 0.0;
        for (int j = 0; j < 4; j++) begin
            c[j] = real'(base[j]) + real'(int'($urandom_range(0, 2 * spread)) - spread);
            n += c[j] * c[j];
        end
        if (n < 1.0) n = 1.0;
        for (int j = 0; j < 4; j++) q[j] = 16'(int'(c[j] * 16384.0 / $sqrt(n)));
    endfunction

    task automatic add_item(logic signed [15:0] s[4], logic signed [15:0] e[4],
                            logic signed [16:0] t);
        slerp_item_t it;
        it.s = s;
        it.e = e;
        it.t = t;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(int n);
        logic signed [15:0] s[4], e[4];
        logic signed [16:0] t;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            rand_quat(s, pick >= 10);
            if (pick < 10)
                rand_quat(e, 0);
            else if (pick < 50)
                rand_quat(e, 1);
            else
                near_quat(e, s, (pick < 75) ? 40 : 2000);
            if ($urandom_range(0, 1)) for (int j = 0; j < 4; j++) e[j] = -e[j];
            if ($urandom_range(0, 9) == 0)
                t = 17'($urandom());
            else
                t = 17'($urandom_range(1, 32767));
            add_item(s, e, t);
        end
    endtask

    task automatic queue_directed();
        logic signed [15:0] idq[4], ax[4], ay[4], neg[4], mx[4], mn[4], big[4];
        idq = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        ax  = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        ay  = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0};
        neg = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        mx  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        mn  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        big = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0};
        // t at or below zero returns start
        add_item(ax, idq, 17'sd0);
        add_item(ax, idq, -17'sd65536);
        add_item(mn, mx, -17'sd1);
        // t at or above one returns end, never negated
        add_item(idq, neg, 17'sd32768);
        add_item(idq, mn, 17'sd65535);
        // trig path, orthogonal and 45 degree
        add_item(idq, ax, 17'sd16384);
        add_item(idq, ax, 17'sd1);
        add_item(idq, ax, 17'sd32767);
        add_item(idq, ay, 17'sd8192);
        // negative dot takes the short arc
        add_item(idq, '{-16'sd11585, 16'sd0, -16'sd11585, 16'sd0}, 17'sd20000);
        // equal quaternions, cosine one
        add_item(idq, idq, 17'sd12345);
        add_item(idq, neg, 17'sd16384);
        // unnormalized, cosine above one, saturation
        add_item(mx, mx, 17'sd16384);
        add_item(mn, mn, 17'sd30000);
        add_item(mn, mx, 17'sd100);
        add_item(big, big, 17'sd16384);
        // negating -32768 in end
        add_item('{16'sd1, 16'sd0, 16'sd0, 16'sd0}, '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0},
                 17'sd16384);
        add_item(ax, '{16'sd0, -16'sd32768, 16'sd0, 16'sd0}, 17'sd1000);
        // near-identical pair, just below and above the linear switch
        add_item(idq, '{16'sd16383, 16'sd181, 16'sd0, 16'sd0}, 17'sd16384);
        add_item(idq, '{16'sd16384, 16'sd2, 16'sd0, 16'sd0}, 17'sd5000);
        // zero quaternions
        add_item('{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
                 17'sd16384);
    endtask

    // wait until all items transferred and checked, then let the pipe drain
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() > 0 || expected_quats.size() > 0 || s_valid);
        repeat (LAT_WAIT) @(posedge aclk);
    endtask

    // register write in setup and access phases; lands on the access-phase edge
    task automatic write_threshold(logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(qslerp_pkg::REG_LINEAR_THRESHOLD) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr_shadow = value[14:0];
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, then phases with different thresholds
    // ------------------------------------------------------------------------
    logic [31:0] thr_list[5] = '{32'd0, 32'd16384, 32'h0000_7FFF, 32'hFFFF_3E80, 32'd16383};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // reset threshold first, then every other setting
        queue_directed();
        queue_random(N_RANDOM);
        wait_idle();
        foreach (thr_list[p]) begin
            write_threshold(thr_list[p]);
            if (p == 1) queue_directed();
            queue_random(N_RANDOM);
            wait_idle();
        end
        $display("covered %0d items, %0d results: %0d bypass, %0d linear, %0d trig",
                 n_in, n_out, n_byp, n_lin, n_trig);
        $display("thresholds swept: reset, 0, 16384, 32767, 16000, 16383");
        if (n_errors == 0 && expected_quats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
